// ----- sv/sbda_pkg.sv -----
package sbda_pkg;

  // ASCII codes, low six bits
  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_MINUS = 6'd45;

  // BCD correction for shift-add-3
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ       = 4'd3;

  localparam int unsigned INPUT_WIDTH = 64;

  // status from the conversion unit to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dabble_status_t;

endpackage

// ----- sv/signed_binary_to_decimal_ascii.sv -----
// Signed binary to decimal ASCII converter.
// The first word is registered after the shift-add-3 conversion of the accepted input word
// and after the leading zeros are dropped (up to DIGITS-1); then one word per cycle while char_stall allows.
// A new number is taken only after the last word of the previous one is registered;
// a negative number emits a minus sign word ahead of its digits.
// Reset (rst, synchronous, active high) empties the output and returns to idle.
module signed_binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                value_valid,
  output logic                                value_stall,
  input  logic signed [sbda_pkg::INPUT_WIDTH-1:0] value,
  output logic                                char_valid,
  input  logic                                char_stall,
  output logic [5:0]                          char_code,
  output logic                                last
);
  import sbda_pkg::*;

  // digits for 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2)
  localparam int unsigned DIGITS = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
  localparam int unsigned IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SKIP, S_EMIT} state_t;

  state_t                 state;
  logic                   neg;
  logic                   sign_pending;
  logic [IDX_W-1:0]       idx;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   start;
  dabble_status_t         dab_status;
  logic [4*DIGITS-1:0]    bcd;
  logic [3:0]             digit;
  logic                   slot_free;

  // magnitude in unsigned arithmetic, so the most negative value is exact
  assign raw   = value[VALUE_WIDTH-1:0];
  assign mag   = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign start = (state == S_IDLE) && value_valid;

  assign value_stall = (state != S_IDLE);
  assign digit       = bcd[4*idx +: 4];
  assign slot_free   = !char_valid || !char_stall;

  sbda_dabble #(
    .MAG_WIDTH (VALUE_WIDTH),
    .DIGITS    (DIGITS)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mag    (mag),
    .status (dab_status),
    .bcd    (bcd)
  );

  // sequencer and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      char_valid   <= 1'b0;
      sign_pending <= 1'b0;
      neg          <= 1'b0;
      idx          <= '0;
    end else begin
      // in S_EMIT the word register is refilled whenever it frees up
      if (char_valid && !char_stall && state != S_EMIT) begin
        char_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (value_valid) begin
            neg   <= raw[VALUE_WIDTH-1];
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (dab_status.done) begin
            idx          <= IDX_W'(DIGITS - 1);
            sign_pending <= neg;
            state        <= S_SKIP;
          end
        end
        // drop leading zeros, keeping at least the units digit
        S_SKIP: begin
          if (idx != '0 && digit == 4'd0) begin
            idx <= idx - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            char_valid <= 1'b1;
            if (sign_pending) begin
              char_code    <= ASCII_MINUS;
              last         <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              char_code <= ASCII_ZERO + {2'b00, digit};
              last      <= (idx == '0);
              if (idx == '0) begin
                state <= S_IDLE;
              end else begin
                idx <= idx - 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/sbda_dabble.sv -----
module sbda_dabble #(
  parameter int unsigned MAG_WIDTH = 64,
  parameter int unsigned DIGITS    = 19
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [MAG_WIDTH-1:0]     mag,
  output sbda_pkg::dabble_status_t status,
  output logic [4*DIGITS-1:0]      bcd
);
  import sbda_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAG_WIDTH + 1);

  logic [MAG_WIDTH-1:0] sr;
  logic [4*DIGITS-1:0]  bcd_reg;
  logic [4*DIGITS-1:0]  bcd_adj;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_reg[4*i +: 4] >= BCD_ADJ_LIMIT) begin
        bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + BCD_ADJ;
      end else begin
        bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
      end
    end
  end

  // one binary bit moves into the BCD word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse after the final shift
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        sr      <= mag;
        bcd_reg <= '0;
        cnt     <= CNT_W'(MAG_WIDTH);
        busy    <= 1'b1;
      end else if (busy) begin
        {bcd_reg, sr} <= {bcd_adj[4*DIGITS-2:0], sr, 1'b0};
        cnt           <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign bcd         = bcd_reg;

endmodule

// ----- tb/ascii_text_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts the ASCII text of every
// accepted number and checks each emitted character in order.
module ascii_text_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    value_valid,
  input  logic                                    value_stall,
  input  logic signed [sbda_pkg::INPUT_WIDTH-1:0] value,
  input  logic                                    char_valid,
  input  logic                                    char_stall,
  input  logic [5:0]                              char_code,
  input  logic                                    last,
  output int                                      errors,
  output int                                      pending_chars,
  output int                                      chars_checked
);
  import sbda_pkg::*;

  localparam logic [63:0] DEC_RADIX = 64'd10;
  localparam int MAX_DIGITS = 20;

  typedef struct packed {
    logic [5:0] code;
    logic       fin;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t want;

  initial begin
    errors = 0;
    pending_chars = 0;
    chars_checked = 0;
  end

  // one line per mismatch, and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // decimal text of one accepted word, most significant digit first
  task automatic queue_decimal_text(input logic [INPUT_WIDTH-1:0] word);
    logic [INPUT_WIDTH-1:0] mag;
    logic [3:0]             digs[MAX_DIGITS];
    logic                   negative;
    int                     nd;
    negative = word[INPUT_WIDTH-1];
    // unsigned magnitude, so the most negative value stays whole
    mag = negative ? (~word + 1'b1) : word;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % DEC_RADIX);
      mag = mag / DEC_RADIX;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (negative)
      expected_text.push_back('{code: ASCII_MINUS, fin: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      expected_text.push_back('{code: ASCII_ZERO + 6'(digs[i]), fin: (i == 0)});
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (value_valid && !value_stall)
        queue_decimal_text(value);
      if (char_valid && !char_stall) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d last %0b", char_code, last));
        end else begin
          want = expected_text.pop_front();
          if (char_code !== want.code)
            report_mismatch($sformatf("char_code %0d, expected %0d", char_code, want.code));
          if (last !== want.fin)
            report_mismatch($sformatf("last %0b, expected %0b (char %0d)",
                                      last, want.fin, want.code));
          chars_checked++;
        end
      end
      pending_chars = expected_text.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import sbda_pkg::*;

  localparam int RANDOM_WORDS = 180;
  localparam int CALM_TAIL = 40;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          value_valid = 1'b0;
  logic                          value_stall;
  logic signed [INPUT_WIDTH-1:0] value = '0;
  logic                          char_valid;
  logic                          char_stall = 1'b0;
  logic [5:0]                    char_code;
  logic                          last;

  int errors;
  int pending_chars;
  int chars_checked;
  int cycles = 0;
  int stall_left = 0;
  int words_sent = 0;
  int negatives_sent = 0;
  bit idle_on = 1'b1;

  signed_binary_to_decimal_ascii #(.VALUE_WIDTH(INPUT_WIDTH)) uut (
    .clk(clk),
    .rst(rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value(value),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_code(char_code),
    .last(last)
  );

  ascii_text_checker checker_i (
    .clk(clk),
    .rst(rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value(value),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_code(char_code),
    .last(last),
    .errors(errors),
    .pending_chars(pending_chars),
    .chars_checked(chars_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still expected", cycles, pending_chars);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver back-pressure in random bursts, started only while idle_on is set
  always @(negedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
    end else if (stall_left > 0) begin
      char_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      char_stall <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      char_stall <= 1'b0;
    end
  end

  // present one word at a falling edge, hold it until accepted
  task automatic send_word(input logic [INPUT_WIDTH-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      value_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    value <= v;
    value_valid <= 1'b1;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    words_sent++;
    if (v[INPUT_WIDTH-1]) negatives_sent++;
    @(negedge clk);
  endtask

  // random word: full range, small numbers, power-of-ten boundaries, short magnitudes
  function automatic logic [INPUT_WIDTH-1:0] random_word();
    logic [INPUT_WIDTH-1:0] w;
    logic [INPUT_WIDTH-1:0] p;
    int k;
    p = 64'd1;
    case ($urandom_range(0, 3))
      0: w = {$urandom, $urandom};
      1: w = 64'($urandom_range(0, 1000));
      2: begin
        k = $urandom_range(0, 18);
        repeat (k) p = p * 64'd10;
        w = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: w = {$urandom, $urandom} >> $urandom_range(1, 63);
    endcase
    if ($urandom_range(0, 1) == 1)
      w = -w;
    return w;
  endfunction

  logic [INPUT_WIDTH-1:0] directed_words[22] = '{
    64'd0, 64'd1, -64'd1, 64'd7, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
    -64'd100, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'd999999999999999999, 64'd1000000000000000000,
    -64'd1000000000000000000, 64'd1234567890123456789, -64'd987654321,
    64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
  };

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners first
    foreach (directed_words[i])
      send_word(directed_words[i]);

    // random part: idling switched per segment, none in the tail
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n >= RANDOM_WORDS - CALM_TAIL)
        idle_on = 1'b0;
      else if (n % 20 == 0)
        idle_on = ($urandom_range(0, 2) != 0);
      send_word(random_word());
    end
    value_valid <= 1'b0;

    wait (pending_chars == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers (%0d negative) to text, %0d characters compared",
             words_sent, negatives_sent, chars_checked);
    $display("Mismatches: %0d, characters still expected: %0d", errors, pending_chars);
    if (errors == 0 && pending_chars == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sbda_pkg.sv
sv/sbda_dabble.sv
sv/signed_binary_to_decimal_ascii.sv
tb/ascii_text_checker.sv
tb/tb.sv
